// File: src/modular_exponentiation_core_defines.svh
// Assertion shorthands shared by the RTL files that check themselves.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Check an implication on every rising edge, held off while reset is active.
`define MEXP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds, held off while reset is active.
`define MEXP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: src/mexp_pkg.sv
package mexp_pkg;

	// Width of every data field on the ports.
	localparam int FIELD_W = 32;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_REDUCE = 6'b000010,
		S_LOAD   = 6'b000100,
		S_MUL    = 6'b001000,
		S_UPDATE = 6'b010000,
		S_FINISH = 6'b100000
	} mexp_state_t;

	// Control of one bit-serial modular multiplier.
	typedef struct packed {
		logic load;
		logic step;
	} mexp_mul_ctrl_t;

endpackage

// File: src/mexp_mulmod.sv
// Bit-serial modular multiplier: r = (x * y) mod m, one bit of y per step,
// most significant bit first. Needs x < m (or x = 1) and a stable m.
module mexp_mulmod import mexp_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  mexp_mul_ctrl_t       ctrl,
	input  logic [WIDTH-1:0]     x,
	input  logic [WIDTH-1:0]     y,
	input  logic [WIDTH-1:0]     m,
	output logic [WIDTH-1:0]     r
);

	localparam int TW = WIDTH + 3;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [TW-1:0]    sum;
	logic [TW-1:0]    diff1;
	logic [TW-1:0]    diff2;
	logic [WIDTH-1:0] acc_next;

	// 2*acc + bit*x stays below 3m: subtract m or 2m by the borrow bits.
	always_comb begin
		sum      = (TW'(acc_q) << 1) + (y_q[WIDTH-1] ? TW'(x_q) : '0);
		diff1    = sum - TW'(m);
		diff2    = sum - (TW'(m) << 1);
		if (!diff2[TW-1]) begin
			acc_next = diff2[WIDTH-1:0];
		end else if (!diff1[TW-1]) begin
			acc_next = diff1[WIDTH-1:0];
		end else begin
			acc_next = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (ctrl.step) begin
			acc_q <= acc_next;
			y_q   <= y_q << 1;
		end
	end

	assign r = acc_q;

endmodule

// File: src/modular_exponentiation_core.sv
// Modular exponentiation: power_result = base_value ^ exponent_value mod modulus_value,
// by right-to-left square-and-multiply over the WIDTH low bits of each operand.
// One request is worked at a time; a new request is taken as soon as the core is
// idle, even while the previous result still waits at the output register. Two
// bit-serial modular multipliers, each retiring one multiplier bit per clock while
// it steps, set the pace: the base is first reduced mod the modulus, then each of
// the WIDTH exponent bits takes an operand load, serial steps over every multiplier
// bit and an accumulator update, with the square and the multiply running side by
// side. A zero modulus goes straight to the finish state with modulus_error set and
// a result of 0. A zero exponent gives 1, even for a modulus of 1. Results wider
// than the 32-bit result port are truncated; operands are zero-extended or
// truncated to WIDTH bits on entry.
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core import mexp_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FIELD_W-1:0] base_value,
	input  logic [FIELD_W-1:0] exponent_value,
	input  logic [FIELD_W-1:0] modulus_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] power_result,
	output logic               modulus_error
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	mexp_state_t state_q;
	logic [CW-1:0] step_cnt_q;   // serial step within one multiply
	logic [CW-1:0] bit_cnt_q;    // exponent bit being processed

	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] acc_q;
	logic             mod_one_q;
	logic             err_q;

	logic               out_valid_q;
	logic [FIELD_W-1:0] result_q;
	logic               result_err_q;

	logic [WIDTH+FIELD_W-1:0] base_wide;
	logic [WIDTH+FIELD_W-1:0] exp_wide;
	logic [WIDTH+FIELD_W-1:0] mod_wide;
	logic [WIDTH+FIELD_W-1:0] acc_wide;
	logic [WIDTH-1:0]         base_w;
	logic [WIDTH-1:0]         exp_w;
	logic [WIDTH-1:0]         mod_w;

	logic             accept;
	logic             finish_go;
	logic             last_step;

	mexp_mul_ctrl_t   ctrl_a;
	mexp_mul_ctrl_t   ctrl_b;
	logic [WIDTH-1:0] mul_a_x;
	logic [WIDTH-1:0] mul_b_x;
	logic [WIDTH-1:0] mul_b_y;
	logic [WIDTH-1:0] prod_w;    // multiply unit result
	logic [WIDTH-1:0] sq_w;      // square unit result: the running square

	// Fit the 32-bit fields to the operand width.
	assign base_wide = {{WIDTH{1'b0}}, base_value};
	assign exp_wide  = {{WIDTH{1'b0}}, exponent_value};
	assign mod_wide  = {{WIDTH{1'b0}}, modulus_value};
	assign base_w    = base_wide[WIDTH-1:0];
	assign exp_w     = exp_wide[WIDTH-1:0];
	assign mod_w     = mod_wide[WIDTH-1:0];
	assign acc_wide  = {{FIELD_W{1'b0}}, acc_q};

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_step = (step_cnt_q == CW'(WIDTH - 1));
	// Hand the result over only when the output register is free.
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// Square unit: reduces the base first (x = 1, y = base), then squares,
	// reloading the running square at every operand load.
	always_comb begin
		ctrl_b.load = accept || (state_q == S_LOAD);
		ctrl_b.step = (state_q == S_REDUCE) || (state_q == S_MUL);
		ctrl_a.load = (state_q == S_LOAD);
		ctrl_a.step = (state_q == S_MUL);
		mul_b_x     = (state_q == S_IDLE) ? WIDTH'(1) : sq_w;
		mul_b_y     = (state_q == S_IDLE) ? base_w : sq_w;
		// The accumulator starts at 1, which a modulus of one reduces to 0.
		mul_a_x     = mod_one_q ? '0 : acc_q;
	end

	mexp_mulmod #(.WIDTH(WIDTH)) u_mul_a (
		.clk  (clk),
		.ctrl (ctrl_a),
		.x    (mul_a_x),
		.y    (sq_w),
		.m    (mod_q),
		.r    (prod_w)
	);

	mexp_mulmod #(.WIDTH(WIDTH)) u_mul_b (
		.clk  (clk),
		.ctrl (ctrl_b),
		.x    (mul_b_x),
		.y    (mul_b_y),
		.m    (mod_q),
		.r    (sq_w)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_cnt_q <= '0;
			bit_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_cnt_q <= '0;
						bit_cnt_q  <= '0;
						// Zero modulus: skip straight to the error result.
						state_q    <= (mod_w == '0) ? S_FINISH : S_REDUCE;
					end
				end
				S_REDUCE: begin
					step_cnt_q <= step_cnt_q + CW'(1);
					if (last_step) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_cnt_q <= '0;
					state_q    <= S_MUL;
				end
				S_MUL: begin
					step_cnt_q <= step_cnt_q + CW'(1);
					if (last_step) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					bit_cnt_q <= bit_cnt_q + CW'(1);
					state_q   <= (bit_cnt_q == CW'(WIDTH - 1)) ? S_FINISH : S_LOAD;
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand and accumulator datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q     <= exp_w;
			mod_q     <= mod_w;
			mod_one_q <= (mod_w == WIDTH'(1));
			err_q     <= (mod_w == '0);
			acc_q     <= WIDTH'(1);
		end else if (state_q == S_UPDATE) begin
			// Take the product when the current exponent bit is set, then advance.
			if (exp_q[0]) begin
				acc_q <= prod_w;
			end
			exp_q <= exp_q >> 1;
		end
	end

	// Output register: holds a finished result while the core starts the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			result_q     <= err_q ? '0 : acc_wide[FIELD_W-1:0];
			result_err_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign power_result  = result_q;
	assign modulus_error = result_err_q;

	`MEXP_ASSERT(a_zero_mod_finishes, accept && (mod_w == '0) |=> state_q == S_FINISH, "zero modulus did not go straight to finish")
	`MEXP_ASSERT(a_error_gives_zero, out_valid && modulus_error |-> power_result == '0, "error result is not zero")
	`MEXP_NEVER(a_square_reduced, (state_q == S_LOAD) && (sq_w >= mod_q), "running square not reduced below the modulus")
	`MEXP_NEVER(a_ready_while_busy, in_ready && (state_q != S_IDLE), "request taken while busy")

endmodule

// File: bench/modular_exponentiation_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the modular exponentiation core. Each request is
// scored against a behavioral power computation built on 64-bit products.
// Random gaps on the request side and random stalls on the result side
// exercise the handshakes, with one long output hold-off to fill the core.
module modular_exponentiation_core_tb import mexp_pkg::*; ();

	// Limit on the whole run, several times the slowest correct run.
	localparam int CYCLE_LIMIT = 3_000_000;
	// Final wait, padded beyond the time that one request takes.
	localparam int SETTLE_CYCLES = 1200;
	// Long output hold-off, longer than two full exponentiations.
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int MAX_GAP = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] power;
		logic               error;
	} power_expect_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [FIELD_W-1:0] base_value = '0;
	logic [FIELD_W-1:0] exponent_value = '0;
	logic [FIELD_W-1:0] modulus_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [FIELD_W-1:0] power_result;
	logic               modulus_error;

	// Expected results, oldest first.
	power_expect_t pending_powers[$];
	int            error_count = 0;
	int            cycle_count = 0;
	// Random idling on both sides when set.
	bit            gaps_on = 1'b1;
	// Cycles for the result side to hold off, picked up by the sink process.
	int            sink_hold = 0;

	modular_exponentiation_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.modulus_value (modulus_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.power_result  (power_result),
		.modulus_error (modulus_error)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Compute base^exponent mod modulus, right to left over the exponent bits.
	// Operands stay below the modulus, so every product fits in 64 bits.
	function automatic power_expect_t predict_power(logic [FIELD_W-1:0] b,
			logic [FIELD_W-1:0] e, logic [FIELD_W-1:0] m);
		power_expect_t res;
		logic [63:0]   acc;
		logic [63:0]   sq;
		logic [63:0]   modv;
		int            i;
		modv = {32'd0, m};
		if (m == '0) begin
			// Zero modulus: flag it and return zero.
			res.power = '0;
			res.error = 1'b1;
			return res;
		end
		// Start at 1; a zero exponent leaves it at 1, even for a modulus of one.
		acc = 64'd1;
		sq  = {32'd0, b} % modv;
		for (i = 0; i < FIELD_W; i++) begin
			if (e[i])
				acc = (acc * sq) % modv;
			sq = (sq * sq) % modv;
		end
		res.power = acc[FIELD_W-1:0];
		res.error = 1'b0;
		return res;
	endfunction

	// Offer one request and hold it until accepted. Entered right after a rising
	// edge; valid stays high on return so a zero gap keeps the stream dense.
	task automatic send_request(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
			logic [FIELD_W-1:0] m);
		int gap;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		base_value     <= b;
		exponent_value <= e;
		modulus_value  <= m;
		do @(posedge clk); while (!in_ready);
		pending_powers.insert(pending_powers.size(), predict_power(b, e, m));
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_powers.size() != 0);
	endtask

	// Pick a request, leaning toward the corners of the arithmetic.
	task automatic draw_request(output logic [FIELD_W-1:0] b,
			output logic [FIELD_W-1:0] e, output logic [FIELD_W-1:0] m);
		b = $urandom();
		e = $urandom();
		m = $urandom();
		case ($urandom_range(0, 11))
			0: m = '0;
			1: m = $urandom_range(1, 16);
			2: e = $urandom_range(0, 3);
			3: b = $urandom_range(0, 1);
			4: b = m - 1;
			5: m = 32'd1;
			6: m = 32'hFFFF_FFFF - $urandom_range(0, 7);
			7: e = 32'd1 << $urandom_range(0, FIELD_W - 1);
			default: ;
		endcase
	endtask

	// Corners: zero and one moduli, zero exponent, all-ones operands, top bits.
	task automatic test_directed();
		send_request(32'd0, 32'd0, 32'd0);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_request(32'd123, 32'd0, 32'd1);
		send_request(32'd5, 32'd3, 32'd1);
		send_request(32'd0, 32'd0, 32'd7);
		send_request(32'd0, 32'd5, 32'd7);
		send_request(32'd2, 32'd10, 32'd1000);
		send_request(32'hFFFF_FFFF, 32'd1, 32'd7);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'd3, 32'hFFFF_FFFF, 32'd4294967291);
		send_request(32'd3, 32'h8000_0000, 32'd4294967291);
		send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);
		send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
		send_request(32'd7, 32'd2, 32'd2);
		send_request(32'd1, 32'hFFFF_FFFF, 32'd2);
		send_request(32'd10, 32'd1, 32'd3);
		drain_results();
	endtask

	// Dense stream: no gaps on either side.
	task automatic test_back_to_back(int count);
		logic [FIELD_W-1:0] b, e, m;
		gaps_on = 1'b0;
		repeat (count) begin
			draw_request(b, e, m);
			send_request(b, e, m);
		end
		drain_results();
		gaps_on = 1'b1;
	endtask

	// Hold the output off long enough that the core finishes one request, takes
	// the next, finishes that too, and then must refuse further requests.
	task automatic test_output_hold_off(int count);
		logic [FIELD_W-1:0] b, e, m;
		gaps_on   = 1'b0;
		sink_hold = HOLD_OFF_CYCLES;
		repeat (count) begin
			draw_request(b, e, m);
			send_request(b, e, m);
		end
		drain_results();
		gaps_on = 1'b1;
	endtask

	// Random requests with random gaps and stalls; pause now and then to drain.
	task automatic test_random(int count);
		logic [FIELD_W-1:0] b, e, m;
		int                 n;
		for (n = 0; n < count; n++) begin
			draw_request(b, e, m);
			send_request(b, e, m);
			if (n % 97 == 96)
				drain_results();
		end
		drain_results();
	endtask

	// Result sink: random stall before each result, plus any requested hold-off.
	initial begin : result_sink
		int n;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				n = sink_hold;
				sink_hold = 0;
				repeat (n) @(posedge clk);
			end
			n = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			// Advance until a result is taken or a hold-off is asked for.
			do @(posedge clk); while (!(out_valid && out_ready) && sink_hold == 0);
		end
	end

	// Score each accepted result against the oldest expectation.
	always @(posedge clk) begin : check_results
		power_expect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_powers.size() == 0) begin
				$display("%0t: unexpected result power=%h error=%b",
					$time, power_result, modulus_error);
				error_count++;
			end else begin
				want = pending_powers.pop_front();
				if (power_result !== want.power) begin
					$display("%0t: power_result expected %h actual %h",
						$time, want.power, power_result);
					error_count++;
				end
				if (modulus_error !== want.error) begin
					$display("%0t: modulus_error expected %b actual %b",
						$time, want.error, modulus_error);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if the cycle count runs away.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main_sequence
		// Hold reset, release it on an edge, then start.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back(40);
		test_output_hold_off(6);
		test_random(476);
		// Let any stray result show up before scoring.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_powers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
